// File: rtl/sled_pkg.sv
// Shared types and constants for the string literal escape decoder.
// No dependencies.
package sled_pkg;

  typedef enum logic [1:0] {
    MODE_AWAIT  = 2'd0,
    MODE_QUOTED = 2'd1,
    MODE_PASS   = 2'd2
  } token_mode_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_OPEN = 2'd1,
    ESC_HEX  = 2'd2,
    ESC_OCT  = 2'd3
  } esc_phase_t;

  typedef struct packed {
    token_mode_t mode;
    esc_phase_t  phase;
    logic [1:0]  oct_cnt;
    logic [7:0]  value;
    logic        quote_pend;
  } sled_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       syntax_error;
    logic       last;
  } sled_result_t;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;
  localparam int FifoCntW  = 3;

  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_LC_B    = 8'h62;
  localparam logic [7:0] CH_LC_F    = 8'h66;
  localparam logic [7:0] CH_LC_N    = 8'h6E;
  localparam logic [7:0] CH_LC_R    = 8'h72;
  localparam logic [7:0] CH_LC_T    = 8'h74;
  localparam logic [7:0] CH_LC_V    = 8'h76;
  localparam logic [7:0] CH_LC_X    = 8'h78;
  localparam logic [7:0] CH_UC_X    = 8'h58;

  localparam logic [7:0] CODE_BS = 8'h08;
  localparam logic [7:0] CODE_FF = 8'h0C;
  localparam logic [7:0] CODE_LF = 8'h0A;
  localparam logic [7:0] CODE_CR = 8'h0D;
  localparam logic [7:0] CODE_HT = 8'h09;
  localparam logic [7:0] CODE_VT = 8'h0B;

  localparam logic [1:0] OCT_MAX = 2'd3;

endpackage

// File: rtl/sled_decode.sv
// Combinational step logic: next token state and up to two results per byte.
// Depends on sled_pkg.
module sled_decode (
  input  sled_pkg::sled_state_t  state,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  input  logic                   error_enable,
  output sled_pkg::sled_state_t  state_nxt,
  output sled_pkg::sled_result_t res0,
  output sled_pkg::sled_result_t res1,
  output logic [1:0]             res_cnt
);
  import sled_pkg::*;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    return r;
  endfunction

  logic       emit_a, emit_b, err, do_body, skip, is_oct;
  logic [7:0] byte_a, byte_b, oct_val;
  logic [4:0] hx;
  logic [1:0] cnt_inc;

  always_comb begin
    state_nxt = state;
    emit_a    = 1'b0;
    emit_b    = 1'b0;
    byte_a    = 8'd0;
    byte_b    = 8'd0;
    err       = 1'b0;
    do_body   = 1'b0;
    skip      = 1'b0;
    hx        = hex_digit(in_byte);
    is_oct    = (in_byte[7:3] == 5'b00110);
    oct_val   = {state.value[4:0], in_byte[2:0]};
    cnt_inc   = 2'(state.oct_cnt + 2'd1);

    case (state.mode)
      MODE_AWAIT: begin
        if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
          state_nxt.mode = MODE_QUOTED;
        end else begin
          state_nxt.mode = MODE_PASS;
          emit_a = 1'b1;
          byte_a = in_byte;
        end
      end
      MODE_PASS: begin
        emit_a = 1'b1;
        byte_a = in_byte;
      end
      default: begin
        if (!in_last) begin
          if (state.quote_pend) begin
            state_nxt.quote_pend = 1'b0;
            if (in_byte == CH_DQUOTE) skip = 1'b1;
            else err = error_enable;
          end
          if (!skip) begin
            case (state.phase)
              ESC_OPEN: begin
                state_nxt.phase = ESC_NONE;
                case (in_byte)
                  CH_LC_B: begin emit_a = 1'b1; byte_a = CODE_BS; end
                  CH_LC_F: begin emit_a = 1'b1; byte_a = CODE_FF; end
                  CH_LC_N: begin emit_a = 1'b1; byte_a = CODE_LF; end
                  CH_LC_R: begin emit_a = 1'b1; byte_a = CODE_CR; end
                  CH_LC_T: begin emit_a = 1'b1; byte_a = CODE_HT; end
                  CH_LC_V: begin emit_a = 1'b1; byte_a = CODE_VT; end
                  CH_NEWLINE: ;
                  CH_LC_X, CH_UC_X: begin
                    state_nxt.phase = ESC_HEX;
                    state_nxt.value = 8'd0;
                  end
                  default: begin
                    if (is_oct) begin
                      state_nxt.phase   = ESC_OCT;
                      state_nxt.value   = {5'd0, in_byte[2:0]};
                      state_nxt.oct_cnt = 2'd1;
                    end else begin
                      emit_a = 1'b1;
                      byte_a = in_byte;
                    end
                  end
                endcase
              end
              ESC_HEX: begin
                if (hx[4]) begin
                  state_nxt.value = {state.value[3:0], hx[3:0]};
                end else begin
                  emit_a          = 1'b1;
                  byte_a          = state.value;
                  state_nxt.phase = ESC_NONE;
                  do_body         = 1'b1;
                end
              end
              ESC_OCT: begin
                if (is_oct && state.oct_cnt < OCT_MAX) begin
                  state_nxt.value   = oct_val;
                  state_nxt.oct_cnt = cnt_inc;
                  if (cnt_inc == OCT_MAX) begin
                    emit_a          = 1'b1;
                    byte_a          = oct_val;
                    state_nxt.phase = ESC_NONE;
                  end
                end else begin
                  emit_a          = 1'b1;
                  byte_a          = state.value;
                  state_nxt.phase = ESC_NONE;
                  do_body         = 1'b1;
                end
              end
              default: do_body = 1'b1;
            endcase
            if (do_body) begin
              if (in_byte == CH_BSLASH) begin
                state_nxt.phase = ESC_OPEN;
              end else if (in_byte == CH_DQUOTE) begin
                state_nxt.quote_pend = 1'b1;
              end else if (emit_a) begin
                emit_b = 1'b1;
                byte_b = in_byte;
              end else begin
                emit_a = 1'b1;
                byte_a = in_byte;
              end
            end
          end
        end else begin
          if (state.quote_pend && in_byte != CH_DQUOTE) err = error_enable;
          if (state.phase == ESC_HEX || state.phase == ESC_OCT) begin
            emit_a = 1'b1;
            byte_a = state.value;
          end
        end
      end
    endcase

    if (in_last) begin
      state_nxt.mode       = MODE_AWAIT;
      state_nxt.phase      = ESC_NONE;
      state_nxt.oct_cnt    = 2'd0;
      state_nxt.value      = 8'd0;
      state_nxt.quote_pend = 1'b0;
    end

    res0.data         = emit_a ? byte_a : 8'd0;
    res0.has_byte     = emit_a;
    res0.syntax_error = err;
    res0.last         = in_last && !emit_b;
    res1.data         = byte_b;
    res1.has_byte     = emit_b;
    res1.syntax_error = 1'b0;
    res1.last         = in_last;

    if (emit_b) res_cnt = 2'd2;
    else if (emit_a || in_last || err) res_cnt = 2'd1;
    else res_cnt = 2'd0;
  end

endmodule

// File: rtl/sled_fifo.sv
// Result queue: takes up to two results per cycle, releases one per request.
// Depends on sled_pkg.
module sled_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             wr_cnt,
  input  sled_pkg::sled_result_t wr_d0,
  input  sled_pkg::sled_result_t wr_d1,
  output logic                   space_ok,
  output logic                   rd_valid,
  input  logic                   rd_ready,
  output sled_pkg::sled_result_t rd_d
);
  import sled_pkg::*;

  sled_result_t          mem_r [FifoDepth];
  logic [FifoPtrW-1:0]   wp_r, rp_r, wp_nxt, rp_nxt;
  logic [FifoCntW-1:0]   cnt_r, cnt_nxt;
  logic                  pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (cnt_r != '0);
  assign rd_d     = mem_r[rp_r];
  assign space_ok = (cnt_r <= FifoCntW'(FifoDepth - 2));

  always_comb begin
    wp_nxt  = FifoPtrW'(wp_r + FifoPtrW'(wr_cnt));
    rp_nxt  = pop ? FifoPtrW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = FifoCntW'(cnt_r + FifoCntW'(wr_cnt) - FifoCntW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) mem_r[wp_r] <= wr_d0;
    if (wr_cnt == 2'd2) mem_r[FifoPtrW'(wp_r + 1'b1)] <= wr_d1;
  end

endmodule

// File: rtl/string_literal_escape_decoder.sv
// String literal escape decoder, top level: input register, token state,
// decode logic and result queue. Depends on sled_pkg, sled_decode, sled_fifo.
// A byte's results pass the input register, then the queue, and leave on out_ready.
// Throughput: one byte per cycle while space_ok; two results drain one per cycle.
// Reset (rst_n low, synchronous): token state idle, queue empty, error_enable 1.
module string_literal_escape_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_syntax_error,
  output logic       out_last
);
  import sled_pkg::*;

  logic         err_en_r;
  logic         s1_valid_r;
  logic [7:0]   s1_byte_r;
  logic         s1_last_r;
  sled_state_t  state_r, state_nxt;
  sled_result_t res0, res1, rd_d;
  logic [1:0]   res_cnt, wr_cnt;
  logic         space_ok, advance;

  assign advance  = s1_valid_r && space_ok;
  assign in_ready = !s1_valid_r || advance;
  assign wr_cnt   = advance ? res_cnt : 2'd0;

  sled_decode u_decode (
    .state        (state_r),
    .in_byte      (s1_byte_r),
    .in_last      (s1_last_r),
    .error_enable (err_en_r),
    .state_nxt    (state_nxt),
    .res0         (res0),
    .res1         (res1),
    .res_cnt      (res_cnt)
  );

  sled_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (wr_cnt),
    .wr_d0    (res0),
    .wr_d1    (res1),
    .space_ok (space_ok),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_d     (rd_d)
  );

  assign out_byte         = rd_d.data;
  assign out_has_byte     = rd_d.has_byte;
  assign out_syntax_error = rd_d.syntax_error;
  assign out_last         = rd_d.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_en_r   <= 1'b1;
      s1_valid_r <= 1'b0;
      state_r    <= '{mode: MODE_AWAIT, phase: ESC_NONE, oct_cnt: 2'd0,
                      value: 8'd0, quote_pend: 1'b0};
    end else begin
      if (cfg_wr_en) err_en_r <= cfg_wr_data;
      if (in_ready) s1_valid_r <= in_valid;
      if (advance) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

endmodule
